>>> hdl/mvs_pkg.sv
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared widths, controller states and command/status types for the
// mean / variance / standard deviation core.
// ----------------------------------------------------------------------------
package mvs_pkg;

	// sample format and set size
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_SAMPLES = 4096;

	// accumulator widths
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SQR_W = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES);
	localparam int SQS_W = SQR_W + $clog2(MAX_SAMPLES) + 1;
	localparam int MAG_W = SUM_W;

	// finishing arithmetic widths
	localparam int QLO_W = 22;
	localparam int QHI_W = SQS_W - QLO_W;
	localparam int PLO_W = CNT_W + QLO_W;
	localparam int PHI_W = CNT_W + QHI_W;
	localparam int MSQ_W = 2 * MAG_W;
	localparam int D_W   = CNT_W + SQS_W - 1;
	localparam int NN_W  = 2 * CNT_W - 1;

	// divider widths
	localparam int DVD_W = D_W + 16;
	localparam int DVS_W = NN_W;
	localparam int QUO_W = 47;
	localparam int DCNT_W = $clog2(DVD_W);

	// square root widths
	localparam int RAD_W  = 48;
	localparam int ROOT_W = RAD_W / 2;
	localparam int SREM_W = ROOT_W + 2;
	localparam int SCNT_W = $clog2(ROOT_W);

	// result widths
	localparam int TOTAL_W = 28;
	localparam int MEAN_W  = 24;
	localparam int VAR_W   = 39;
	localparam int STD_W   = 24;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAIT,
		ST_MAG,
		ST_MUL1,
		ST_MUL2,
		ST_NQ,
		ST_DIFF,
		ST_DIVM_GO,
		ST_DIVM,
		ST_DIVV_GO,
		ST_DIVV,
		ST_SQRT_GO,
		ST_SQRT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic mag_en;
		logic mul1_en;
		logic mul2_en;
		logic nq_en;
		logic diff_en;
		logic divm_go;
		logic mean_en;
		logic divv_go;
		logic var_en;
		logic sqrt_go;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic sqrt_done;
	} sts_t;

endpackage

>>> hdl/mvs_div.sv
// ----------------------------------------------------------------------------
// mvs_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvs_div
	import mvs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;

	logic [DVS_W:0]    trial;
	logic              fits;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// control: run flag, step count, finish pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q[QUO_W-1:0];

endmodule

>>> hdl/mvs_sqrt.sv
// ----------------------------------------------------------------------------
// mvs_sqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module mvs_sqrt
	import mvs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  rad_q;
	logic [SREM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;

	logic [SREM_W+1:0] shifted;
	logic [SREM_W+1:0] trial;
	logic              fits;

	// bring down two radicand bits and try root*4+1
	assign shifted = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial   = (SREM_W + 2)'({root_q, 2'b01});
	assign fits    = shifted >= trial;

	// control: run flag, step count, finish pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SCNT_W'(ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and partial root
	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? SREM_W'(shifted - trial) : shifted[SREM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hdl/mvs_datapath.sv
// ----------------------------------------------------------------------------
// mvs_datapath
// Accumulators, finishing multiplies, shared divider, square root and
// result registers for the mean / variance / standard deviation core.
// ----------------------------------------------------------------------------
module mvs_datapath
	import mvs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [SAMPLE_BITS-1:0]   sample,
	output logic                     done,
	output logic [TOTAL_W-1:0]       total,
	output logic [MEAN_W-1:0]        mean_q8,
	output logic [VAR_W-1:0]         variance_q8,
	output logic [STD_W-1:0]         std_dev_q8,
	output logic [CNT_W-1:0]         sample_count,
	output logic                     overflow
);

	// input stage
	logic signed [SAMPLE_BITS-1:0] samp_s1;
	logic [SQR_W-1:0]              sq_s1;
	logic                          vld_s1;
	logic signed [2*SAMPLE_BITS-1:0] sq_full;

	// accumulators
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQS_W-1:0]        sqs_q;
	logic                    ovf_q;

	// finishing registers
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic [MSQ_W-1:0] msq_q;
	logic [PLO_W-1:0] plo_q;
	logic [PHI_W-1:0] phi_q;
	logic [NN_W-1:0]  nn_q;
	logic [D_W-1:0]   nq_q;
	logic [D_W-1:0]   d_q;
	logic [MEAN_W-1:0] mean_q;
	logic [QUO_W-1:0] x_q;

	// result registers
	logic              done_q;
	logic [TOTAL_W-1:0] total_q;
	logic [MEAN_W-1:0] mean_out_q;
	logic [VAR_W-1:0]  var_out_q;
	logic [STD_W-1:0]  std_out_q;
	logic [CNT_W-1:0]  cnt_out_q;
	logic              ovf_out_q;

	// divider and root hookups
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_done;
	logic [QUO_W-1:0]  div_quo;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic [D_W:0]      nq_sum;
	logic [D_W:0]      diff;

	function automatic logic signed [2*SAMPLE_BITS-1:0] samp_mul(
		input logic [SAMPLE_BITS-1:0] s
	);
		logic signed [SAMPLE_BITS-1:0] v;
		v = $signed(s);
		return v * v;
	endfunction

	// square of the incoming sample
	assign sq_full = samp_mul(sample);

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			samp_s1 <= $signed(sample);
			sq_s1   <= sq_full[SQR_W-1:0];
		end
	end

	// accumulate, saturate the count, clear once the result is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqs_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load_out) begin
			count_q <= '0;
			sum_q   <= '0;
			sqs_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (vld_s1) begin
			if (count_q >= CNT_W'(MAX_SAMPLES)) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(samp_s1);
				sqs_q   <= sqs_q + SQS_W'(sq_s1);
			end
		end
	end

	// n*Q split in two halves, S*S and n*n
	assign nq_sum = (D_W + 1)'({phi_q, {QLO_W{1'b0}}}) + (D_W + 1)'(plo_q);
	assign diff   = (D_W + 1)'(nq_q) - (D_W + 1)'(msq_q);

	always_ff @(posedge clk) begin
		if (cmd.mag_en) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
		end
		if (cmd.mul1_en) begin
			msq_q <= mag_q * mag_q;
			plo_q <= count_q * sqs_q[QLO_W-1:0];
		end
		if (cmd.mul2_en) begin
			phi_q <= count_q * sqs_q[SQS_W-1:QLO_W];
			nn_q  <= count_q * count_q;
		end
		if (cmd.nq_en) begin
			nq_q <= nq_sum[D_W-1:0];
		end
		if (cmd.diff_en) begin
			d_q <= diff[D_W-1:0];
		end
		if (cmd.mean_en) begin
			mean_q <= neg_q ? MEAN_W'(-div_quo[MEAN_W-1:0]) : div_quo[MEAN_W-1:0];
		end
		if (cmd.var_en) begin
			x_q <= div_quo;
		end
	end

	// shared divider: mean first, then scaled variance
	assign div_dvd = cmd.divv_go ? {d_q, 16'h0000} : DVD_W'({mag_q, 8'h00});
	assign div_dvs = cmd.divv_go ? nn_q : DVS_W'(count_q);

	mvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.divm_go | cmd.divv_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	mvs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.sqrt_go),
		.radicand (RAD_W'(x_q)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.load_out;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			total_q    <= TOTAL_W'(sum_q);
			mean_out_q <= mean_q;
			var_out_q  <= x_q[QUO_W-1:8];
			std_out_q  <= sqrt_root;
			cnt_out_q  <= count_q;
			ovf_out_q  <= ovf_q;
		end
	end

	assign done         = done_q;
	assign total        = total_q;
	assign mean_q8      = mean_out_q;
	assign variance_q8  = var_out_q;
	assign std_dev_q8   = std_out_q;
	assign sample_count = cnt_out_q;
	assign overflow     = ovf_out_q;

endmodule

>>> hdl/mvs_ctrl.sv
// ----------------------------------------------------------------------------
// mvs_ctrl
// Sequencer for the mean / variance / standard deviation core: accepts
// samples while idle and steps the datapath through the finishing math.
// ----------------------------------------------------------------------------
module mvs_ctrl
	import mvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic last,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.take = start;
				if (start && last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag_en = 1'b1;
				state_d    = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1_en = 1'b1;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2_en = 1'b1;
				state_d     = ST_NQ;
			end
			ST_NQ: begin
				cmd.nq_en = 1'b1;
				state_d   = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = ST_DIVM_GO;
			end
			ST_DIVM_GO: begin
				cmd.divm_go = 1'b1;
				state_d     = ST_DIVM;
			end
			ST_DIVM: begin
				if (sts.div_done) begin
					cmd.mean_en = 1'b1;
					state_d     = ST_DIVV_GO;
				end
			end
			ST_DIVV_GO: begin
				cmd.divv_go = 1'b1;
				state_d     = ST_DIVV;
			end
			ST_DIVV: begin
				if (sts.div_done) begin
					cmd.var_en = 1'b1;
					state_d    = ST_SQRT_GO;
				end
			end
			ST_SQRT_GO: begin
				cmd.sqrt_go = 1'b1;
				state_d     = ST_SQRT;
			end
			ST_SQRT: begin
				if (sts.sqrt_done) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/mean_variance_stddev_core.sv
// ----------------------------------------------------------------------------
// mean_variance_stddev_core
// Population sum, mean, variance and standard deviation over a set of
// signed samples; statistics in Q.8 fixed point.
//
//   channel  | handshake           | fields
//   ---------+---------------------+----------------------------------------
//   input    | start & !busy       | sample, last
//   result   | done (one cycle)    | total, mean_q8, variance_q8,
//            |                     | std_dev_q8, sample_count, overflow
//
// Samples are taken one per cycle while busy is low. A transaction with
// last high makes busy rise; busy then stays high through the finishing
// multiplies, the shared one-bit-per-cycle divider (two passes of 72 steps)
// and the 24-step square root. done pulses for one cycle with the result and
// busy falls in that same cycle. The receiver cannot stall the result. Reset
// clears the count, sums and overflow flag.
// ----------------------------------------------------------------------------
module mean_variance_stddev_core
	import mvs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last,
	output logic                   done,
	output logic [TOTAL_W-1:0]     total,
	output logic [MEAN_W-1:0]      mean_q8,
	output logic [VAR_W-1:0]       variance_q8,
	output logic [STD_W-1:0]       std_dev_q8,
	output logic [CNT_W-1:0]       sample_count,
	output logic                   overflow
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	mvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// arithmetic
	mvs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.done         (done),
		.total        (total),
		.mean_q8      (mean_q8),
		.variance_q8  (variance_q8),
		.std_dev_q8   (std_dev_q8),
		.sample_count (sample_count),
		.overflow     (overflow)
	);

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mean_variance_stddev_core. Sample transactions
// go in through start/busy. A scoreboard class keeps its own count, sum,
// sum of squares and overflow flag. For every set it predicts total, mean,
// variance, standard deviation, count and overflow. Each done pulse is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mvs_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int RANDOM_ITEMS = 700;
	localparam int CALM_ITEMS   = 150;
	localparam int DRAIN_CYCLES = 400;

	// one expected set result
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [MEAN_W-1:0]  mean;
		logic [VAR_W-1:0]   variance;
		logic [STD_W-1:0]   sd;
		logic [CNT_W-1:0]   n;
		logic               ovf;
	} set_stats_t;

	// set statistics predictor and result checker
	class stats_scoreboard;
		int unsigned fill;
		longint      acc_sum;
		longint      acc_sq;
		bit          dropped;
		set_stats_t  pending_stats[$];
		int unsigned mismatches;
		int unsigned sets_checked;
		int unsigned samples_taken;

		// floor square root, one result bit per step from the top
		function longint floor_sqrt(longint x);
			longint root;
			longint cand;
			root = 0;
			for (int b = STD_W - 1; b >= 0; b--) begin
				cand = root | (longint'(1) << b);
				if (cand * cand <= x)
					root = cand;
			end
			return root;
		endfunction

		// note an accepted sample transaction
		function void take_sample(logic [SAMPLE_BITS-1:0] raw, logic is_last);
			longint     s;
			longint     mag;
			longint     nn;
			longint     diff;
			longint     whole;
			longint     rem;
			longint     q;
			set_stats_t e;
			s = longint'($signed(raw));
			samples_taken++;
			if (fill >= MAX_SAMPLES)
				dropped = 1'b1;
			else begin
				fill++;
				acc_sum += s;
				acc_sq += s * s;
			end
			if (!is_last)
				return;
			e = '0;
			e.total = acc_sum[TOTAL_W-1:0];
			e.n = fill[CNT_W-1:0];
			e.ovf = dropped;
			if (fill != 0) begin
				mag = (acc_sum < 0) ? -acc_sum : acc_sum;
				nn = longint'(fill) * longint'(fill);
				diff = longint'(fill) * acc_sq - mag * mag;
				whole = diff / nn;
				rem = diff % nn;
				q = mag * 256 / longint'(fill);
				e.mean = (acc_sum < 0) ? MEAN_W'(-q) : MEAN_W'(q);
				e.variance = VAR_W'(whole * 256 + (rem * 256) / nn);
				e.sd = STD_W'(floor_sqrt(whole * 65536 + (rem * 65536) / nn));
			end
			pending_stats.push_back(e);
			fill = 0;
			acc_sum = 0;
			acc_sq = 0;
			dropped = 1'b0;
		endfunction

		function void check_field(string label, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t mismatch on %s: expected %0h actual %0h",
					$time, label, want, got);
				mismatches++;
			end
		endfunction

		// compare one result against the oldest prediction
		function void check_result(logic [TOTAL_W-1:0] t, logic [MEAN_W-1:0] m,
			logic [VAR_W-1:0] v, logic [STD_W-1:0] d, logic [CNT_W-1:0] n, logic o);
			set_stats_t e;
			if (pending_stats.size() == 0) begin
				$display("%0t unexpected result: expected none actual total %0h count %0d",
					$time, t, n);
				mismatches++;
				return;
			end
			e = pending_stats.pop_front();
			sets_checked++;
			check_field("total", e.total, t);
			check_field("mean_q8", e.mean, m);
			check_field("variance_q8", e.variance, v);
			check_field("std_dev_q8", e.sd, d);
			check_field("sample_count", e.n, n);
			check_field("overflow", e.ovf, o);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic                   last = 1'b0;
	logic                   busy;
	logic                   done;
	logic [TOTAL_W-1:0]     total;
	logic [MEAN_W-1:0]      mean_q8;
	logic [VAR_W-1:0]       variance_q8;
	logic [STD_W-1:0]       std_dev_q8;
	logic [CNT_W-1:0]       sample_count;
	logic                   overflow;

	stats_scoreboard board = new;
	bit              idle_on;
	int unsigned     cycles;
	int unsigned     random_sent;

	mean_variance_stddev_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.last(last),
		.done(done),
		.total(total),
		.mean_q8(mean_q8),
		.variance_q8(variance_q8),
		.std_dev_q8(std_dev_q8),
		.sample_count(sample_count),
		.overflow(overflow)
	);

	// 12 ns clock
	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("[mean_variance_stddev_core] ERROR");
			$finish;
		end
	end

	// monitor: accepted transactions and result strobes
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.take_sample(sample, last);
			if (done)
				board.check_result(total, mean_q8, variance_q8, std_dev_q8,
					sample_count, overflow);
		end
	end

	// drive one sample and hold it until accepted
	task automatic send_sample(logic [SAMPLE_BITS-1:0] s, logic is_last);
		start <= 1'b1;
		sample <= s;
		last <= is_last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random idle burst between transactions
	task automatic maybe_idle();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15))
				@(posedge clk);
		end
	endtask

	// wait for every predicted result to come back
	task automatic drain();
		start <= 1'b0;
		// let the monitor note the last accepted transaction first
		@(posedge clk);
		while (board.pending_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_set(int vals[$]);
		foreach (vals[i]) begin
			maybe_idle();
			send_sample(SAMPLE_BITS'(vals[i]), i == vals.size() - 1);
		end
	endtask

	// sample value by flavor: full range, extremes, near zero, near the rails
	function automatic logic [SAMPLE_BITS-1:0] pick_sample(int flavor);
		logic [SAMPLE_BITS-1:0] v;
		case (flavor)
			0: v = SAMPLE_BITS'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: v = 16'h7fff;
					1: v = 16'h8000;
					2: v = 16'h0000;
					default: v = 16'hffff;
				endcase
			end
			2: v = SAMPLE_BITS'($urandom_range(0, 32)) - 16'd16;
			default: v = $urandom_range(0, 1) ? 16'h8000 + SAMPLE_BITS'($urandom_range(0, 255))
				: 16'h7fff - SAMPLE_BITS'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	// stimulus
	initial begin
		int len;
		int flavor;

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one-sample sets, extremes, rounding of negative means
		idle_on = 1'b0;
		send_set('{32767});
		send_set('{-32768});
		send_set('{0});
		send_set('{-32768, 32767});
		send_set('{-1, 0, 0});
		send_set('{32767, -32768, 32767, -32768});
		send_set('{5, -7, 100});
		idle_on = 1'b1;
		send_set('{1, 2, 3, 4});
		send_set('{-3, -3, -4, 21845, -21846});

		// full set at the limit with maximum spread, no overflow
		idle_on = 1'b0;
		for (int i = 0; i < MAX_SAMPLES; i++)
			send_sample((i % 2) ? 16'h7fff : 16'h8000, i == MAX_SAMPLES - 1);

		// overflowing set of most negative samples; the three samples past the limit, the last among them, are dropped
		idle_on = 1'b1;
		for (int i = 0; i < MAX_SAMPLES + 3; i++) begin
			maybe_idle();
			send_sample((i < MAX_SAMPLES) ? 16'h8000 : pick_sample(0),
				i == MAX_SAMPLES + 2);
		end
		drain();

		// random sets, mostly short, idling switched per set
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0: len = $urandom_range(65, 300);
				1, 2, 3, 4, 5: len = $urandom_range(13, 64);
				default: len = $urandom_range(1, 12);
			endcase
			flavor = $urandom_range(0, 3);
			idle_on = (random_sent + CALM_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 2) != 0);
			for (int i = 0; i < len; i++) begin
				maybe_idle();
				send_sample(pick_sample($urandom_range(0, 4) == 0 ? 0 : flavor),
					i == len - 1);
			end
			random_sent += len;
			if (random_sent > RANDOM_ITEMS / 2 && random_sent - len <= RANDOM_ITEMS / 2)
				drain();
		end

		// end of run
		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (board.pending_stats.size() != 0) begin
			$display("%0t %0d results never arrived", $time, board.pending_stats.size());
			board.mismatches++;
		end
		$display("covered %0d sample transactions over %0d sets,", board.samples_taken,
			board.sets_checked);
		$display("including a full-size set and an overflowing set with a dropped last sample");
		if (board.mismatches == 0)
			$display("[mean_variance_stddev_core] OK");
		else
			$display("[mean_variance_stddev_core] ERROR");
		$finish;
	end

endmodule
